// ===== design/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and codes for the modulation matrix engine.
// ----------------------------------------------------------------------------
package mme_pkg;

  typedef enum logic [2:0] {
    MODE_SAMPLE = 3'd0,
    MODE_ADD    = 3'd1,
    MODE_SET    = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_REMT   = 3'd4,
    MODE_REMS   = 3'd5,
    MODE_CLEAR  = 3'd6,
    MODE_TICK   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_DUP    = 3'd1,
    STAT_FULL   = 3'd2,
    STAT_NF     = 3'd3,
    STAT_NOTGT  = 3'd4
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [3:0]         source_index;
    logic [7:0]         target_id;
    logic [15:0]        sample;
    logic signed [15:0] amount;
    logic               symmetric;
    logic               link_enable;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         out_target;
    logic signed [23:0] modulation_sum;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [3:0]         src;
    logic [7:0]         tgt;
    logic signed [15:0] amt;
    logic               sym;
    logic               en;
  } link_t;

  localparam logic signed [23:0] SUM_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SUM_MIN = 24'sh800000;
  localparam logic [16:0]        HALF    = 17'd32768;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_IDX_INC,
    OP_IDX_CLR,
    OP_LINK_RD,
    OP_SCAN_NOTE,
    OP_SET_DUP,
    OP_SET_FIELDS,
    OP_DROP_START,
    OP_END_SCAN,
    OP_ADD_NEW,
    OP_TTAB_RD_MAP,
    OP_TTAB_INC,
    OP_TTAB_NEW,
    OP_LINK_MOVE,
    OP_TTAB_DEC,
    OP_TTAB_RD_LAST,
    OP_TTAB_MOVE,
    OP_SUM_CLR,
    OP_TK_MUL,
    OP_SUM_RD_MAP,
    OP_SUM_ACC,
    OP_SET_NOTGT,
    OP_OUT_RD,
    OP_OUT_TGT,
    OP_EMIT_CTL
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  link_end;
    logic  tgt_end;
    logic  full;
    logic  hit;
    logic  link_en;
    logic  found_tgt;
    logic  refs_one;
    logic  tcount_zero;
    logic  last_tgt;
    logic  out_free;
  } stat_t;

endpackage

// ===== design/mme_ram.sv =====
// ----------------------------------------------------------------------------
// mme_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/mme_ctrl.sv =====
// ----------------------------------------------------------------------------
// mme_ctrl
// Sequencer: walks the link and target tables for table commands and ticks.
// ----------------------------------------------------------------------------
module mme_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  mme_pkg::mode_t   in_mode,
  output logic             in_ready,
  input  mme_pkg::stat_t   stat,
  output mme_pkg::cmd_t    cmd
);

  typedef enum logic [19:0] {
    ST_IDLE      = 20'h00001,
    ST_SCAN_RD   = 20'h00002,
    ST_SCAN_CHK  = 20'h00004,
    ST_ADD_LINK  = 20'h00008,
    ST_ADD_TRD   = 20'h00010,
    ST_ADD_TINC  = 20'h00020,
    ST_ADD_TNEW  = 20'h00040,
    ST_DROP_MOVE = 20'h00080,
    ST_DROP_MAP  = 20'h00100,
    ST_DROP_TCHK = 20'h00200,
    ST_DROP_TMOV = 20'h00400,
    ST_TICK_CLR  = 20'h00800,
    ST_TICK_LRD  = 20'h01000,
    ST_TICK_LCHK = 20'h02000,
    ST_TICK_MAP  = 20'h04000,
    ST_TICK_ACC  = 20'h08000,
    ST_OUT_RD    = 20'h10000,
    ST_OUT_LD    = 20'h20000,
    ST_EMIT      = 20'h40000,
    ST_SPARE     = 20'h80000
  } state_t;

  state_t state_r, state_nxt;
  mme_pkg::dp_op_t op;
  state_t drop_done;

  assign in_ready = (state_r == ST_IDLE);
  assign cmd.op   = op;
  // single-link remove ends after one drop, bulk removes keep scanning
  assign drop_done = (stat.mode == mme_pkg::MODE_REMOVE) ? ST_EMIT : ST_SCAN_RD;

  always_comb begin
    state_nxt = state_r;
    op        = mme_pkg::OP_NOP;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op = mme_pkg::OP_LATCH;
          case (in_mode)
            mme_pkg::MODE_SAMPLE, mme_pkg::MODE_CLEAR: state_nxt = ST_EMIT;
            mme_pkg::MODE_ADD: state_nxt = stat.full ? ST_EMIT : ST_SCAN_RD;
            mme_pkg::MODE_TICK: state_nxt = ST_TICK_CLR;
            default: state_nxt = ST_SCAN_RD;
          endcase
        end
      end
      ST_SCAN_RD: begin
        if (stat.link_end) begin
          if (stat.mode == mme_pkg::MODE_ADD) begin
            state_nxt = ST_ADD_LINK;
          end else begin
            op        = mme_pkg::OP_END_SCAN;
            state_nxt = ST_EMIT;
          end
        end else begin
          op        = mme_pkg::OP_LINK_RD;
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (!stat.hit) begin
          op        = mme_pkg::OP_SCAN_NOTE;
          state_nxt = ST_SCAN_RD;
        end else if (stat.mode == mme_pkg::MODE_ADD) begin
          op        = mme_pkg::OP_SET_DUP;
          state_nxt = ST_EMIT;
        end else if (stat.mode == mme_pkg::MODE_SET) begin
          op        = mme_pkg::OP_SET_FIELDS;
          state_nxt = ST_EMIT;
        end else begin
          op        = mme_pkg::OP_DROP_START;
          state_nxt = ST_DROP_MOVE;
        end
      end
      ST_ADD_LINK: begin
        op        = mme_pkg::OP_ADD_NEW;
        state_nxt = stat.found_tgt ? ST_ADD_TRD : ST_ADD_TNEW;
      end
      ST_ADD_TRD: begin
        op        = mme_pkg::OP_TTAB_RD_MAP;
        state_nxt = ST_ADD_TINC;
      end
      ST_ADD_TINC: begin
        op        = mme_pkg::OP_TTAB_INC;
        state_nxt = ST_EMIT;
      end
      ST_ADD_TNEW: begin
        op        = mme_pkg::OP_TTAB_NEW;
        state_nxt = ST_EMIT;
      end
      ST_DROP_MOVE: begin
        op        = mme_pkg::OP_LINK_MOVE;
        state_nxt = ST_DROP_MAP;
      end
      ST_DROP_MAP: begin
        op        = mme_pkg::OP_TTAB_RD_MAP;
        state_nxt = ST_DROP_TCHK;
      end
      ST_DROP_TCHK: begin
        if (stat.refs_one) begin
          op        = mme_pkg::OP_TTAB_RD_LAST;
          state_nxt = ST_DROP_TMOV;
        end else begin
          op        = mme_pkg::OP_TTAB_DEC;
          state_nxt = drop_done;
        end
      end
      ST_DROP_TMOV: begin
        op        = mme_pkg::OP_TTAB_MOVE;
        state_nxt = drop_done;
      end
      ST_TICK_CLR: begin
        if (stat.tgt_end) begin
          op        = mme_pkg::OP_IDX_CLR;
          state_nxt = ST_TICK_LRD;
        end else begin
          op = mme_pkg::OP_SUM_CLR;
        end
      end
      ST_TICK_LRD: begin
        if (!stat.link_end) begin
          op        = mme_pkg::OP_LINK_RD;
          state_nxt = ST_TICK_LCHK;
        end else if (stat.tcount_zero) begin
          op        = mme_pkg::OP_SET_NOTGT;
          state_nxt = ST_EMIT;
        end else begin
          op        = mme_pkg::OP_IDX_CLR;
          state_nxt = ST_OUT_RD;
        end
      end
      ST_TICK_LCHK: begin
        if (stat.link_en) begin
          op        = mme_pkg::OP_TK_MUL;
          state_nxt = ST_TICK_MAP;
        end else begin
          op        = mme_pkg::OP_IDX_INC;
          state_nxt = ST_TICK_LRD;
        end
      end
      ST_TICK_MAP: begin
        op        = mme_pkg::OP_SUM_RD_MAP;
        state_nxt = ST_TICK_ACC;
      end
      ST_TICK_ACC: begin
        op        = mme_pkg::OP_SUM_ACC;
        state_nxt = ST_TICK_LRD;
      end
      ST_OUT_RD: begin
        op        = mme_pkg::OP_OUT_RD;
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (stat.out_free) begin
          op        = mme_pkg::OP_OUT_TGT;
          state_nxt = stat.last_tgt ? ST_IDLE : ST_OUT_RD;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          op        = mme_pkg::OP_EMIT_CTL;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/mme_dp.sv =====
// ----------------------------------------------------------------------------
// mme_dp
// Datapath: link, target, target-map and sum memories, counters, MAC.
// ----------------------------------------------------------------------------
module mme_dp #(
  parameter int MAX_LINKS   = 32,
  parameter int NUM_SOURCES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  mme_pkg::cmd_t  cmd,
  output mme_pkg::stat_t stat,
  input  mme_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mme_pkg::out_t  out_data
);

  localparam int LCW = $clog2(MAX_LINKS + 1);
  localparam int AW  = $clog2(MAX_LINKS);
  localparam int TEW = 8 + LCW;
  localparam int LW  = $bits(mme_pkg::link_t);

  mme_pkg::in_t     op_r, op_nxt;
  logic [LCW-1:0]   lcount_r, lcount_nxt, tcount_r, tcount_nxt, idx_r, idx_nxt;
  logic [15:0]      samples_r [16];
  logic [15:0]      samples_nxt [16];
  mme_pkg::status_t status_r, status_nxt;
  logic             found_r, found_nxt, dropped_r, dropped_nxt;
  logic [7:0]       cur_tgt_r, cur_tgt_nxt;
  logic [AW-1:0]    t_r, t_nxt;
  logic [32:0]      prod_r, prod_nxt;
  logic             out_valid_r, out_valid_nxt;
  mme_pkg::out_t    out_r, out_nxt;

  logic             l_we, l_re;
  logic [AW-1:0]    l_waddr, l_raddr;
  mme_pkg::link_t   l_wdata, l_q;
  logic [LW-1:0]    l_qv;
  logic             t_we, t_re;
  logic [AW-1:0]    t_waddr, t_raddr;
  logic [TEW-1:0]   t_wdata, t_q;
  logic             m_we, m_re;
  logic [7:0]       m_waddr, m_raddr;
  logic [AW-1:0]    m_wdata, m_q;
  logic             s_we, s_re;
  logic [AW-1:0]    s_waddr, s_raddr;
  logic [23:0]      s_wdata, s_q;

  logic [LCW-1:0]     lm1, tm1;
  logic [7:0]         tq_id;
  logic [LCW-1:0]     tq_refs;
  logic               pair_match, hit, out_free;
  logic signed [16:0] dval;
  logic signed [16:0] qval;
  logic signed [24:0] sum25;
  logic [23:0]        sat_sum;

  assign l_q     = mme_pkg::link_t'(l_qv);
  assign lm1     = lcount_r - LCW'(1);
  assign tm1     = tcount_r - LCW'(1);
  assign tq_id   = t_q[TEW-1 -: 8];
  assign tq_refs = t_q[LCW-1:0];
  assign out_free = !out_valid_r || out_ready;

  assign pair_match = (l_q.src == op_r.source_index) && (l_q.tgt == op_r.target_id);
  always_comb begin
    case (op_r.mode)
      mme_pkg::MODE_REMT: hit = (l_q.tgt == op_r.target_id);
      mme_pkg::MODE_REMS: hit = (l_q.src == op_r.source_index);
      default:            hit = pair_match;
    endcase
  end

  // symmetric links center the sample on one half
  assign dval  = l_q.sym ? $signed({1'b0, samples_r[l_q.src]} - mme_pkg::HALF)
                         : $signed({1'b0, samples_r[l_q.src]});
  // upper bits of the product = shift right 16 rounding toward minus infinity
  assign qval  = $signed(prod_r[32:16]);
  assign sum25 = $signed({s_q[23], s_q}) + $signed({{8{qval[16]}}, qval});
  assign sat_sum = (sum25[24] != sum25[23]) ? (sum25[24] ? mme_pkg::SUM_MIN : mme_pkg::SUM_MAX)
                                            : sum25[23:0];

  assign stat.mode        = op_r.mode;
  assign stat.link_end    = (idx_r == lcount_r);
  assign stat.tgt_end     = (idx_r == tcount_r);
  assign stat.full        = (lcount_r == LCW'(MAX_LINKS));
  assign stat.hit         = hit;
  assign stat.link_en     = l_q.en;
  assign stat.found_tgt   = found_r;
  assign stat.refs_one    = (tq_refs == LCW'(1));
  assign stat.tcount_zero = (tcount_r == '0);
  assign stat.last_tgt    = (idx_r == tm1);
  assign stat.out_free    = out_free;

  always_comb begin
    op_nxt        = op_r;
    lcount_nxt    = lcount_r;
    tcount_nxt    = tcount_r;
    idx_nxt       = idx_r;
    samples_nxt   = samples_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    dropped_nxt   = dropped_r;
    cur_tgt_nxt   = cur_tgt_r;
    t_nxt         = t_r;
    prod_nxt      = prod_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    l_we = 1'b0; l_waddr = idx_r[AW-1:0]; l_wdata = l_q;
    l_re = 1'b0; l_raddr = idx_r[AW-1:0];
    t_we = 1'b0; t_waddr = t_r; t_wdata = t_q;
    t_re = 1'b0; t_raddr = idx_r[AW-1:0];
    m_we = 1'b0; m_waddr = op_r.target_id; m_wdata = t_r;
    m_re = 1'b0; m_raddr = op_r.target_id;
    s_we = 1'b0; s_waddr = t_r; s_wdata = sat_sum;
    s_re = 1'b0; s_raddr = idx_r[AW-1:0];
    case (cmd.op)
      mme_pkg::OP_LATCH: begin
        op_nxt      = in_data;
        idx_nxt     = '0;
        found_nxt   = 1'b0;
        dropped_nxt = 1'b0;
        status_nxt  = (in_data.mode == mme_pkg::MODE_ADD && stat.full) ? mme_pkg::STAT_FULL
                                                                        : mme_pkg::STAT_OK;
        if (in_data.mode == mme_pkg::MODE_SAMPLE && 32'(in_data.source_index) < NUM_SOURCES) begin
          samples_nxt[in_data.source_index] = in_data.sample;
        end
        if (in_data.mode == mme_pkg::MODE_CLEAR) begin
          lcount_nxt = '0;
          tcount_nxt = '0;
        end
      end
      mme_pkg::OP_IDX_INC: idx_nxt = idx_r + LCW'(1);
      mme_pkg::OP_IDX_CLR: idx_nxt = '0;
      mme_pkg::OP_LINK_RD: l_re = 1'b1;
      mme_pkg::OP_SCAN_NOTE: begin
        found_nxt = found_r || (l_q.tgt == op_r.target_id);
        idx_nxt   = idx_r + LCW'(1);
      end
      mme_pkg::OP_SET_DUP: status_nxt = mme_pkg::STAT_DUP;
      mme_pkg::OP_SET_FIELDS: begin
        l_we    = 1'b1;
        l_wdata = '{src: op_r.source_index, tgt: op_r.target_id, amt: op_r.amount,
                    sym: op_r.symmetric, en: op_r.link_enable};
      end
      mme_pkg::OP_DROP_START: begin
        cur_tgt_nxt = l_q.tgt;
        dropped_nxt = 1'b1;
        l_re        = 1'b1;
        l_raddr     = lm1[AW-1:0];
      end
      mme_pkg::OP_END_SCAN: status_nxt = dropped_r ? mme_pkg::STAT_OK : mme_pkg::STAT_NF;
      mme_pkg::OP_ADD_NEW: begin
        l_we       = 1'b1;
        l_waddr    = lcount_r[AW-1:0];
        l_wdata    = '{src: op_r.source_index, tgt: op_r.target_id, amt: 16'sd0,
                       sym: 1'b0, en: 1'b1};
        lcount_nxt = lcount_r + LCW'(1);
        m_re       = 1'b1;
      end
      mme_pkg::OP_TTAB_RD_MAP: begin
        t_re    = 1'b1;
        t_raddr = m_q;
        t_nxt   = m_q;
      end
      mme_pkg::OP_TTAB_INC: begin
        t_we    = 1'b1;
        t_wdata = {tq_id, tq_refs + LCW'(1)};
      end
      mme_pkg::OP_TTAB_NEW: begin
        t_we       = 1'b1;
        t_waddr    = tcount_r[AW-1:0];
        t_wdata    = {op_r.target_id, LCW'(1)};
        m_we       = 1'b1;
        m_wdata    = tcount_r[AW-1:0];
        tcount_nxt = tcount_r + LCW'(1);
      end
      mme_pkg::OP_LINK_MOVE: begin
        // last link fills the freed slot
        l_we       = 1'b1;
        lcount_nxt = lm1;
        m_re       = 1'b1;
        m_raddr    = cur_tgt_r;
      end
      mme_pkg::OP_TTAB_DEC: begin
        t_we    = 1'b1;
        t_wdata = {tq_id, tq_refs - LCW'(1)};
      end
      mme_pkg::OP_TTAB_RD_LAST: begin
        t_re    = 1'b1;
        t_raddr = tm1[AW-1:0];
      end
      mme_pkg::OP_TTAB_MOVE: begin
        t_we       = 1'b1;
        m_we       = 1'b1;
        m_waddr    = tq_id;
        tcount_nxt = tm1;
      end
      mme_pkg::OP_SUM_CLR: begin
        s_we    = 1'b1;
        s_waddr = idx_r[AW-1:0];
        s_wdata = '0;
        idx_nxt = idx_r + LCW'(1);
      end
      mme_pkg::OP_TK_MUL: begin
        prod_nxt = 33'($signed(33'(dval)) * $signed(33'(l_q.amt)));
        m_re     = 1'b1;
        m_raddr  = l_q.tgt;
      end
      mme_pkg::OP_SUM_RD_MAP: begin
        s_re    = 1'b1;
        s_raddr = m_q;
        t_nxt   = m_q;
      end
      mme_pkg::OP_SUM_ACC: begin
        s_we    = 1'b1;
        idx_nxt = idx_r + LCW'(1);
      end
      mme_pkg::OP_SET_NOTGT: status_nxt = mme_pkg::STAT_NOTGT;
      mme_pkg::OP_OUT_RD: begin
        t_re = 1'b1;
        s_re = 1'b1;
      end
      mme_pkg::OP_OUT_TGT: begin
        out_nxt       = '{status: mme_pkg::STAT_OK, out_target: tq_id,
                          modulation_sum: s_q, last: stat.last_tgt};
        out_valid_nxt = 1'b1;
        idx_nxt       = idx_r + LCW'(1);
      end
      mme_pkg::OP_EMIT_CTL: begin
        out_nxt       = '{status: status_r, out_target: 8'd0,
                          modulation_sum: 24'sd0, last: 1'b1};
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcount_r    <= '0;
      tcount_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        samples_r[i] <= '0;
      end
    end else begin
      lcount_r    <= lcount_nxt;
      tcount_r    <= tcount_nxt;
      out_valid_r <= out_valid_nxt;
      samples_r   <= samples_nxt;
    end
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    status_r  <= status_nxt;
    found_r   <= found_nxt;
    dropped_r <= dropped_nxt;
    cur_tgt_r <= cur_tgt_nxt;
    t_r       <= t_nxt;
    prod_r    <= prod_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  mme_ram #(.WIDTH(LW), .DEPTH(MAX_LINKS)) u_links (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_qv)
  );

  mme_ram #(.WIDTH(TEW), .DEPTH(MAX_LINKS)) u_targets (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_q)
  );

  // target id -> slot in the target table
  mme_ram #(.WIDTH(AW), .DEPTH(256)) u_map (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .re(m_re), .raddr(m_raddr), .rdata(m_q)
  );

  mme_ram #(.WIDTH(24), .DEPTH(MAX_LINKS)) u_sums (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_q)
  );

`ifndef ASSERT_OFF
  // counts only agree between commands; a drop lowers the link count first
  a_tcount_le_lcount: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == mme_pkg::OP_LATCH |-> tcount_r <= lcount_r) else $error("more targets than links");

  a_lcount_max: assert property (@(posedge clk) disable iff (!rst_n)
    lcount_r <= LCW'(MAX_LINKS)) else $error("link count overflow");

  a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == mme_pkg::OP_LINK_MOVE |-> lcount_r != '0) else $error("link drop on empty table");

  a_tmove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == mme_pkg::OP_TTAB_MOVE |-> tcount_r != '0) else $error("target drop on empty table");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == mme_pkg::OP_OUT_TGT || cmd.op == mme_pkg::OP_EMIT_CTL) |-> out_free)
    else $error("result overwritten before transfer");
`endif

endmodule

// ===== design/modulation_matrix_engine_top.sv =====
// ----------------------------------------------------------------------------
// modulation_matrix_engine_top
// Modulation matrix: link table, target table and per-target tick sums.
// ----------------------------------------------------------------------------
// One command at a time. Commands that look up a link scan the link table
// one link at a time and then present the result; removals also move the
// last link, and the last target when a target loses its last link, into the
// freed slots. A tick runs a sum clear sweep over the targets, one
// read-multiply-accumulate pass per enabled link through the dual-port sum
// memory, then one read per emitted result, and stalls only while the result
// register waits for a transfer.
// The next command is accepted while the last result is still waiting.
module modulation_matrix_engine_top #(
  parameter int MAX_LINKS   = 32,
  parameter int NUM_SOURCES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mme_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mme_pkg::out_t out_data
);

  mme_pkg::cmd_t  cmd;
  mme_pkg::stat_t stat;

  mme_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_mode(in_data.mode), .in_ready, .stat, .cmd
  );

  mme_dp #(.MAX_LINKS(MAX_LINKS), .NUM_SOURCES(NUM_SOURCES)) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_data, .out_valid, .out_ready, .out_data
  );

endmodule

// ===== test/modulation_matrix_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// modulation_matrix_engine_top_tb
// Drives link table commands, sample writes and ticks into the modulation
// matrix engine, predicts every result from a behavioral copy of the link
// and target tables, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module modulation_matrix_engine_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLINK = 32;
  localparam int NSRC  = 16;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  mme_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  mme_pkg::out_t out_data;

  always #2 clk = ~clk;

  modulation_matrix_engine_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predicted engine state
  logic [15:0]     smp_mem [NSRC];
  mme_pkg::link_t  lnk [NLINK];
  int              n_links;
  logic [7:0]      tgt_id [NLINK];
  int              tgt_refs [NLINK];
  int              n_tgts;

  mme_pkg::out_t pending_results[$];
  int   n_errors;
  bit   quiet;          // no random idling when set

  function automatic int find_link_idx(logic [3:0] s, logic [7:0] t);
    for (int i = 0; i < n_links; i++)
      if (lnk[i].src == s && lnk[i].tgt == t) return i;
    return -1;
  endfunction

  function automatic int find_tgt_idx(logic [7:0] t);
    for (int i = 0; i < n_tgts; i++)
      if (tgt_id[i] == t) return i;
    return -1;
  endfunction

  function automatic void unlink(int i);
    logic [7:0] t;
    int k;
    t = lnk[i].tgt;
    lnk[i] = lnk[n_links-1];
    n_links--;
    k = find_tgt_idx(t);
    if (k >= 0) begin
      if (tgt_refs[k] > 0) tgt_refs[k]--;
      if (tgt_refs[k] == 0) begin
        tgt_id[k] = tgt_id[n_tgts-1];
        tgt_refs[k] = tgt_refs[n_tgts-1];
        n_tgts--;
      end
    end
  endfunction

  function automatic int unlink_matching(bit by_tgt, logic [7:0] key);
    int i, n;
    i = 0;
    n = 0;
    while (i < n_links) begin
      if ((by_tgt ? lnk[i].tgt : {4'd0, lnk[i].src}) == key) begin
        unlink(i);
        n++;
      end else begin
        i++;
      end
    end
    return n;
  endfunction

  function automatic mme_pkg::out_t ctl_result(mme_pkg::status_t st);
    mme_pkg::out_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Applies one command to the predicted tables and queues its results.
  function automatic void predict_matrix(mme_pkg::in_t c);
    mme_pkg::status_t st;
    int li, k;
    longint sums [NLINK];
    longint d, p, q;
    mme_pkg::out_t r;
    st = mme_pkg::STAT_OK;
    case (c.mode)
      mme_pkg::MODE_SAMPLE: smp_mem[c.source_index] = c.sample;
      mme_pkg::MODE_ADD: begin
        if (n_links >= NLINK) st = mme_pkg::STAT_FULL;
        else if (find_link_idx(c.source_index, c.target_id) >= 0) st = mme_pkg::STAT_DUP;
        else begin
          lnk[n_links] = '{src: c.source_index, tgt: c.target_id, amt: '0,
                           sym: 1'b0, en: 1'b1};
          n_links++;
          k = find_tgt_idx(c.target_id);
          if (k >= 0) tgt_refs[k]++;
          else begin
            tgt_id[n_tgts] = c.target_id;
            tgt_refs[n_tgts] = 1;
            n_tgts++;
          end
        end
      end
      mme_pkg::MODE_SET: begin
        li = find_link_idx(c.source_index, c.target_id);
        if (li < 0) st = mme_pkg::STAT_NF;
        else begin
          lnk[li].amt = c.amount;
          lnk[li].sym = c.symmetric;
          lnk[li].en  = c.link_enable;
        end
      end
      mme_pkg::MODE_REMOVE: begin
        li = find_link_idx(c.source_index, c.target_id);
        if (li < 0) st = mme_pkg::STAT_NF;
        else unlink(li);
      end
      mme_pkg::MODE_REMT: if (unlink_matching(1'b1, c.target_id) == 0) st = mme_pkg::STAT_NF;
      mme_pkg::MODE_REMS: begin
        if (unlink_matching(1'b0, {4'd0, c.source_index}) == 0) st = mme_pkg::STAT_NF;
      end
      mme_pkg::MODE_CLEAR: begin
        n_links = 0;
        n_tgts = 0;
      end
      default: begin
        for (int i = 0; i < NLINK; i++) sums[i] = 0;
        for (int i = 0; i < n_links; i++) begin
          if (!lnk[i].en) continue;
          d = longint'(smp_mem[lnk[i].src]);
          if (lnk[i].sym) d -= 32768;
          p = d * longint'(lnk[i].amt);
          q = p >>> 16;  // floor
          k = find_tgt_idx(lnk[i].tgt);
          if (k >= 0) begin
            sums[k] += q;
            if (sums[k] > 8388607) sums[k] = 8388607;
            if (sums[k] < -8388608) sums[k] = -8388608;
          end
        end
        if (n_tgts == 0) pending_results.push_back(ctl_result(mme_pkg::STAT_NOTGT));
        for (int i = 0; i < n_tgts; i++) begin
          r.status = mme_pkg::STAT_OK;
          r.out_target = tgt_id[i];
          r.modulation_sum = sums[i][23:0];
          r.last = (i == n_tgts - 1);
          pending_results.push_back(r);
        end
        return;
      end
    endcase
    pending_results.push_back(ctl_result(st));
  endfunction

  task automatic send_cmd(mme_pkg::in_t c);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 8) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    predict_matrix(c);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic cmd(mme_pkg::mode_t m, int s = 0, int t = 0, int smp = 0, int amt = 0,
                     bit sy = 0, bit en = 1);
    mme_pkg::in_t c;
    c.mode = m;
    c.source_index = s[3:0];
    c.target_id = t[7:0];
    c.sample = smp[15:0];
    c.amount = amt[15:0];
    c.symmetric = sy;
    c.link_enable = en;
    send_cmd(c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        n_errors++;
      end else begin
        mme_pkg::out_t e;
        e = pending_results.pop_front();
        if (out_data.status !== e.status || out_data.out_target !== e.out_target ||
            out_data.modulation_sum !== e.modulation_sum || out_data.last !== e.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
          n_errors++;
        end
      end
    end
  end

  task automatic test_directed();
    cmd(mme_pkg::MODE_TICK);                                // no targets
    cmd(mme_pkg::MODE_SAMPLE, 0, 0, 16'hFFFF);
    cmd(mme_pkg::MODE_SAMPLE, 15, 0, 0);
    cmd(mme_pkg::MODE_ADD, 0, 255);
    cmd(mme_pkg::MODE_ADD, 0, 255);                         // duplicate
    cmd(mme_pkg::MODE_ADD, 15, 255);
    cmd(mme_pkg::MODE_ADD, 0, 0);
    cmd(mme_pkg::MODE_SET, 0, 255, 0, -32768, 1, 1);
    cmd(mme_pkg::MODE_SET, 15, 255, 0, 32767, 1, 1);
    cmd(mme_pkg::MODE_SET, 0, 0, 0, 32767, 0, 0);
    cmd(mme_pkg::MODE_SET, 3, 3, 0, 5, 0, 1);              // not found
    cmd(mme_pkg::MODE_TICK);
    cmd(mme_pkg::MODE_REMOVE, 0, 255);
    cmd(mme_pkg::MODE_REMOVE, 0, 255);                      // not found
    cmd(mme_pkg::MODE_TICK);
    cmd(mme_pkg::MODE_REMT, 0, 0);
    cmd(mme_pkg::MODE_REMT, 0, 9);
    cmd(mme_pkg::MODE_REMS, 15, 0);
    cmd(mme_pkg::MODE_REMS, 15, 0);
    cmd(mme_pkg::MODE_CLEAR);
    cmd(mme_pkg::MODE_TICK);
    drain();
  endtask

  // add links (repeats are duplicates), load one target with many links, then add two more
  task automatic test_full_table();
    for (int i = 0; i < 16; i++) cmd(mme_pkg::MODE_SAMPLE, i, 0, 16'hFFFF);
    for (int i = 0; i < NLINK; i++) begin
      cmd(mme_pkg::MODE_ADD, i % 16, i < 24 ? 7 : 100 + i);
      cmd(mme_pkg::MODE_SET, i % 16, i < 24 ? 7 : 100 + i, 0, 32767, 0, 1);
    end
    cmd(mme_pkg::MODE_ADD, 1, 7);                           // duplicate
    cmd(mme_pkg::MODE_ADD, 1, 200);
    cmd(mme_pkg::MODE_TICK);
    for (int i = 0; i < 24; i++) cmd(mme_pkg::MODE_SET, i % 16, 7, 0, -32768, 0, 1);
    cmd(mme_pkg::MODE_TICK);
    cmd(mme_pkg::MODE_REMS, 3);
    cmd(mme_pkg::MODE_TICK);
    drain();
    cmd(mme_pkg::MODE_CLEAR);
  endtask

  task automatic test_random(int n_items);
    int m;
    for (int i = 0; i < n_items; i++) begin
      quiet = (i >= n_items / 3 && i < n_items / 2);
      m = $urandom_range(99);
      if (i == n_items / 2) drain();
      if (m < 12) cmd(mme_pkg::MODE_SAMPLE, $urandom_range(15), 0, $urandom);
      else if (m < 40) cmd(mme_pkg::MODE_ADD, $urandom_range(7), $urandom_range(5) == 0 ?
                           $urandom_range(255) : $urandom_range(7));
      else if (m < 60) cmd(mme_pkg::MODE_SET, $urandom_range(7), $urandom_range(7), 0,
                           $urandom, $urandom_range(1), $urandom_range(5) != 0);
      else if (m < 70) cmd(mme_pkg::MODE_REMOVE, $urandom_range(7), $urandom_range(7));
      else if (m < 74) cmd(mme_pkg::MODE_REMT, $urandom_range(15), $urandom_range(9));
      else if (m < 78) cmd(mme_pkg::MODE_REMS, $urandom_range(15), $urandom_range(255));
      else if (m < 80) cmd(mme_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
      else cmd(mme_pkg::MODE_TICK, $urandom, $urandom, $urandom, $urandom,
               $urandom_range(1), $urandom_range(1));
    end
    quiet = 0;
  endtask

  initial begin
    n_errors = 0;
    quiet = 0;
    n_links = 0;
    n_tgts = 0;
    for (int i = 0; i < NSRC; i++) smp_mem[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(230);
    drain();
    repeat (200) @(posedge clk);
    if (n_errors == 0) $display("modulation_matrix_engine_top_tb: clean");
    else $display("modulation_matrix_engine_top_tb: errors");
    $finish;
  end

  initial begin
    #4ms;
    $display("modulation_matrix_engine_top_tb: errors");
    $finish;
  end

endmodule
